[src/assert_macros.svh]
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is asserted
`define KDLP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// checked on every rising edge, reset included
`define KDLP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

[src/kdlp_pkg.sv]
// types, constants and key encoder for the key debouncer
`default_nettype none

package kdlp_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef logic [CodeW-1:0]  key_code_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CfgW-1:0]   cfg_t;

  localparam key_code_t KeyNone  = 3'd0;
  localparam key_code_t KeyK3    = 3'd1;
  localparam key_code_t KeyK2    = 3'd2;
  localparam key_code_t KeyK1    = 3'd3;
  localparam key_code_t KeyK1K3  = 3'd4;

  localparam cfg_t ChatterReset = 8'd3;
  localparam cfg_t RepeatReset  = 8'd50;
  localparam cfg_t LongReset    = 8'd100;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_CHATTER = 2'd0,
    REG_REPEAT  = 2'd1,
    REG_LONG    = 2'd2
  } reg_idx_e;

  function automatic key_code_t encode_keys(input logic k1, input logic k2, input logic k3);
    key_code_t code;
    if (k1) begin
      code = k3 ? KeyK1K3 : KeyK1;
    end else if (k2) begin
      code = KeyK2;
    end else if (k3) begin
      code = KeyK3;
    end else begin
      code = KeyNone;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

[src/key_debounce_long_press.sv]
// top level: key debouncer with short press, long press and auto-repeat
// throughput: one word per cycle unless the output stalls, set by the single state update stage
// an input register and a result register separate the two channels
// reset clears the valid flags and debounce state, limits return to 3, 50 and 100
`default_nettype none

module key_debounce_long_press (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kdlp_pkg::AddrW-1:0]  paddr,
  input  wire logic [kdlp_pkg::DataW-1:0]  pwdata,
  output      logic [kdlp_pkg::DataW-1:0]  prdata,
  output      logic                        pready,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic                        key1_pressed_i,
  input  wire logic                        key2_pressed_i,
  input  wire logic                        key3_pressed_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [2:0]                  key_code_o,
  output      logic                        long_press_o
);

  `include "assert_macros.svh"

  kdlp_pkg::cfg_t chatter_q, repeat_q, long_q;
  kdlp_pkg::reg_idx_e cfg_idx;
  logic cfg_wr;

  logic in_valid_q;
  logic op_q, key1_q, key2_q, key3_q;
  logic out_valid_q;
  kdlp_pkg::key_code_t key_code_q, key_code_d;
  logic long_press_q, long_press_d;

  kdlp_pkg::key_code_t pending_q, pending_d;
  kdlp_pkg::key_code_t previous_q, previous_d;
  kdlp_pkg::count_t    count_q, count_d;
  kdlp_pkg::key_code_t latched_q, latched_d;
  logic                long_flag_q, long_flag_d;

  kdlp_pkg::key_code_t pend;
  kdlp_pkg::count_t    count_inc;
  logic [kdlp_pkg::CountW:0] chatter_p1;
  logic out_free, fire;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = kdlp_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      kdlp_pkg::REG_CHATTER: prdata = {{(kdlp_pkg::DataW-kdlp_pkg::CfgW){1'b0}}, chatter_q};
      kdlp_pkg::REG_REPEAT:  prdata = {{(kdlp_pkg::DataW-kdlp_pkg::CfgW){1'b0}}, repeat_q};
      kdlp_pkg::REG_LONG:    prdata = {{(kdlp_pkg::DataW-kdlp_pkg::CfgW){1'b0}}, long_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chatter_q <= kdlp_pkg::ChatterReset;
      repeat_q  <= kdlp_pkg::RepeatReset;
      long_q    <= kdlp_pkg::LongReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        kdlp_pkg::REG_CHATTER: chatter_q <= pwdata[kdlp_pkg::CfgW-1:0];
        kdlp_pkg::REG_REPEAT:  repeat_q  <= pwdata[kdlp_pkg::CfgW-1:0];
        kdlp_pkg::REG_LONG:    long_q    <= pwdata[kdlp_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= operation_i;
      key1_q <= key1_pressed_i;
      key2_q <= key2_pressed_i;
      key3_q <= key3_pressed_i;
    end
  end

  // scan and read update
  assign count_inc  = count_q + kdlp_pkg::count_t'(1);
  assign chatter_p1 = {1'b0, chatter_q} + {{kdlp_pkg::CountW{1'b0}}, 1'b1};

  always_comb begin
    pending_d   = pending_q;
    previous_d  = previous_q;
    count_d     = count_q;
    latched_d   = latched_q;
    long_flag_d = long_flag_q;
    key_code_d  = latched_q;
    pend        = (pending_q == kdlp_pkg::KeyNone)
                  ? kdlp_pkg::encode_keys(key1_q, key2_q, key3_q) : pending_q;
    if (kdlp_pkg::op_e'(op_q) == kdlp_pkg::OP_READ) begin
      latched_d = kdlp_pkg::KeyNone;
    end else begin
      pending_d = pend;
      if (pend == kdlp_pkg::KeyNone) begin
        previous_d  = kdlp_pkg::KeyNone;
        long_flag_d = 1'b0;
        count_d     = '0;
      end else if (pend != previous_q) begin
        previous_d = pend;
        count_d    = '0;
      end else begin
        pending_d = kdlp_pkg::KeyNone;
        count_d   = count_inc;
        if (count_inc > chatter_q) begin
          if ({1'b0, count_inc} > chatter_p1) begin
            if (count_inc > repeat_q && count_inc > long_q) begin
              count_d     = repeat_q + kdlp_pkg::count_t'(1);
              latched_d   = previous_q;
              long_flag_d = 1'b1;
            end
          end else begin
            latched_d = previous_q;
          end
        end else begin
          long_flag_d = 1'b0;
        end
      end
      key_code_d = latched_d;
    end
    long_press_d = long_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= kdlp_pkg::KeyNone;
      previous_q  <= kdlp_pkg::KeyNone;
      count_q     <= '0;
      latched_q   <= kdlp_pkg::KeyNone;
      long_flag_q <= 1'b0;
    end else if (fire) begin
      pending_q   <= pending_d;
      previous_q  <= previous_d;
      count_q     <= count_d;
      latched_q   <= latched_d;
      long_flag_q <= long_flag_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      key_code_q   <= key_code_d;
      long_press_q <= long_press_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = key_code_q;
  assign long_press_o = long_press_q;

  `KDLP_ASSERT(a_idle_count_zero, clk_i, rst_ni,
               previous_q == kdlp_pkg::KeyNone |-> count_q == '0)
  `KDLP_ASSERT(a_long_needs_key, clk_i, rst_ni,
               long_flag_q |-> previous_q != kdlp_pkg::KeyNone)
  `KDLP_ASSERT(a_pending_tracks_prev, clk_i, rst_ni,
               pending_q != kdlp_pkg::KeyNone |-> pending_q == previous_q)
  `KDLP_ASSERT_ALWAYS(a_stall_cause, clk_i,
                      in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for key_debounce_long_press: directed table, random holds, scoreboard
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit = 200000;
  localparam int NumRows = 24;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    kdlp_pkg::key_code_t code;
    logic                long_press;
  } key_word_t;

  typedef struct {
    kdlp_pkg::op_e       op;
    logic [2:0]          keys;
    bit                  typed;
    kdlp_pkg::key_code_t code;
    logic                long_press;
  } key_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [kdlp_pkg::AddrW-1:0] paddr = '0;
  logic [kdlp_pkg::DataW-1:0] pwdata = '0;
  logic [kdlp_pkg::DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic key1_pressed_i = 1'b0;
  logic key2_pressed_i = 1'b0;
  logic key3_pressed_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] key_code_o;
  logic long_press_o;

  // debouncer state and limits as the block should hold them
  kdlp_pkg::cfg_t chatter_lim = kdlp_pkg::ChatterReset;
  kdlp_pkg::cfg_t rep_start = kdlp_pkg::RepeatReset;
  kdlp_pkg::cfg_t long_lim = kdlp_pkg::LongReset;
  kdlp_pkg::key_code_t pend_code = kdlp_pkg::KeyNone;
  kdlp_pkg::key_code_t prev_code = kdlp_pkg::KeyNone;
  kdlp_pkg::count_t hold_cnt = '0;
  kdlp_pkg::key_code_t latch_key = kdlp_pkg::KeyNone;
  logic long_flag = 1'b0;

  key_word_t expected_keys[$];
  int err_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_holding = 1'b0;
  logic hold_go = 1'b0;

  // keys are {key1, key2, key3}
  key_row_t key_rows [NumRows] = '{
    '{kdlp_pkg::OP_READ, 3'b111, 1'b1, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b000, 1'b1, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b101, 1'b1, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b101, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b101, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b101, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b101, 1'b1, kdlp_pkg::KeyK1K3, 1'b0},
    '{kdlp_pkg::OP_READ, 3'b000, 1'b1, kdlp_pkg::KeyK1K3, 1'b0},
    '{kdlp_pkg::OP_READ, 3'b010, 1'b1, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b110, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b010, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b010, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b011, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b011, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b100, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b100, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b001, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b000, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b000, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b111, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b111, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_READ, 3'b101, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_SCAN, 3'b000, 1'b0, kdlp_pkg::KeyNone, 1'b0},
    '{kdlp_pkg::OP_READ, 3'b000, 1'b0, kdlp_pkg::KeyNone, 1'b0}
  };

  key_debounce_long_press DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .key1_pressed_i (key1_pressed_i),
    .key2_pressed_i (key2_pressed_i),
    .key3_pressed_i (key3_pressed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_code_o     (key_code_o),
    .long_press_o   (long_press_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic kdlp_pkg::key_code_t code_of_keys(input logic [2:0] keys);
    kdlp_pkg::key_code_t code;
    if (keys[2]) begin
      code = keys[0] ? kdlp_pkg::KeyK1K3 : kdlp_pkg::KeyK1;
    end else if (keys[1]) begin
      code = kdlp_pkg::KeyK2;
    end else if (keys[0]) begin
      code = kdlp_pkg::KeyK3;
    end else begin
      code = kdlp_pkg::KeyNone;
    end
    return code;
  endfunction

  function automatic key_word_t debounce_word(input kdlp_pkg::op_e op, input logic [2:0] keys);
    key_word_t word;
    if (op == kdlp_pkg::OP_READ) begin
      word.code = latch_key;
      word.long_press = long_flag;
      latch_key = kdlp_pkg::KeyNone;
    end else begin
      if (pend_code == kdlp_pkg::KeyNone) begin
        pend_code = code_of_keys(keys);
      end
      if (pend_code == kdlp_pkg::KeyNone) begin
        prev_code = kdlp_pkg::KeyNone;
        long_flag = 1'b0;
        hold_cnt = '0;
      end else begin
        hold_cnt = hold_cnt + 8'd1;
        if (pend_code != prev_code) begin
          prev_code = pend_code;
          hold_cnt = '0;
        end else begin
          pend_code = kdlp_pkg::KeyNone;
          if (hold_cnt > chatter_lim) begin
            if ({1'b0, hold_cnt} > {1'b0, chatter_lim} + 9'd1) begin
              if (hold_cnt > rep_start && hold_cnt > long_lim) begin
                hold_cnt = rep_start + 8'd1;
                latch_key = prev_code;
                long_flag = 1'b1;
              end
            end else begin
              latch_key = prev_code;
            end
          end else begin
            long_flag = 1'b0;
          end
        end
      end
      word.code = latch_key;
      word.long_press = long_flag;
    end
    return word;
  endfunction

  task automatic send_word(input kdlp_pkg::op_e op, input logic [2:0] keys, input bit typed,
                           input key_word_t typed_word);
    key_word_t word;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    key1_pressed_i <= keys[2];
    key2_pressed_i <= keys[1];
    key3_pressed_i <= keys[0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    word = debounce_word(op, keys);
    expected_keys.push_back(typed ? typed_word : word);
    words_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input kdlp_pkg::cfg_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= kdlp_pkg::AddrW'(idx) << 2;
    pwdata <= kdlp_pkg::DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      kdlp_pkg::REG_CHATTER: chatter_lim = value;
      kdlp_pkg::REG_REPEAT:  rep_start = value;
      kdlp_pkg::REG_LONG:    long_lim = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(input kdlp_pkg::cfg_t chatter, input kdlp_pkg::cfg_t rep,
                            input kdlp_pkg::cfg_t lng);
    cfg_write(kdlp_pkg::REG_CHATTER, chatter);
    cfg_write(kdlp_pkg::REG_REPEAT, rep);
    cfg_write(kdlp_pkg::REG_LONG, lng);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly clean key holds of random length, some noise and stray reads
  task automatic run_keys(input int budget);
    int stop_at;
    int pick;
    int hold_len;
    int first_fire;
    int span;
    logic [2:0] keys;
    stop_at = words_sent + budget;
    first_fire = int'(chatter_lim) + 2;
    if (int'(rep_start) + 1 > first_fire) first_fire = int'(rep_start) + 1;
    if (int'(long_lim) + 1 > first_fire) first_fire = int'(long_lim) + 1;
    span = first_fire + 3 * (first_fire - int'(rep_start)) + 4;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        keys = 3'($urandom_range(7, 1));
        hold_len = $urandom_range(1) ? $urandom_range(int'(chatter_lim) + 3, 1)
                                     : $urandom_range(span, 1);
        repeat (hold_len) begin
          if ($urandom_range(19) == 0) send_word(kdlp_pkg::OP_READ, 3'($urandom), 1'b0, '0);
          send_word(kdlp_pkg::OP_SCAN, keys, 1'b0, '0);
        end
        repeat ($urandom_range(3, 1)) send_word(kdlp_pkg::OP_SCAN, 3'b000, 1'b0, '0);
      end else if (pick < 85) begin
        repeat ($urandom_range(8, 1)) begin
          send_word(kdlp_pkg::op_e'($urandom_range(1)), 3'($urandom_range(7)), 1'b0, '0);
        end
      end else begin
        send_word(kdlp_pkg::OP_READ, 3'($urandom_range(7)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= rx_holding || ($urandom_range(99) < rx_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_holding <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_holding <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    key_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected word: key_code %0d long_press %0b", key_code_o, long_press_o);
        err_count++;
      end else begin
        want = expected_keys.pop_front();
        if (key_code_o !== want.code) begin
          $error("key_code: expected %0d, got %0d", want.code, key_code_o);
          err_count++;
        end
        if (long_press_o !== want.long_press) begin
          $error("long_press: expected %0b, got %0b", want.long_press, long_press_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tx_idle_pct = 8;
    rx_idle_pct <= 76;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (key_rows[i]) begin
      send_word(key_rows[i].op, key_rows[i].keys, key_rows[i].typed,
                '{key_rows[i].code, key_rows[i].long_press});
    end
    drain();

    set_limits(8'd3, 8'd5, 8'd12);
    cfg_write(RegUnused, 8'hFF);
    run_keys(130);
    drain();
    set_limits(8'd0, 8'd1, 8'd2);
    run_keys(130);
    drain();

    tx_idle_pct = 76;
    rx_idle_pct <= 8;
    set_limits(8'd250, 8'd252, 8'd254);
    run_keys(400);
    drain();
    set_limits(8'd10, 8'd2, 8'd6);
    run_keys(130);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_limits(8'd1, 8'd20, 8'd8);
    hold_go <= 1'b1;
    run_keys(130);
    drain();

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
